// File: design/scan_code_line_buffer_unit_defines.svh
// Assertion macros for the scan code line buffer checker.
`ifndef SCAN_CODE_LINE_BUFFER_UNIT_DEFINES_SVH
`define SCAN_CODE_LINE_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled during reset.
`define SCB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, disabled during reset.
`define SCB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/scb_pkg.sv
// Package: constants, key tables and control structs of the scan code line buffer.
package scb_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int MAX_READ     = 16;
	localparam int NUM_KEYS     = 60;

	localparam logic [7:0] CODE_BACKSPACE = 8'd14;
	localparam logic [7:0] CODE_ENTER     = 8'd28;
	localparam logic [7:0] CODE_CAPS      = 8'd58;
	localparam logic [7:0] DIGIT_LO       = 8'd2;
	localparam logic [7:0] DIGIT_HI       = 8'd13;

	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;

	localparam logic [2:0] KIND_NONE      = 3'd0;
	localparam logic [2:0] KIND_ECHO      = 3'd1;
	localparam logic [2:0] KIND_BS        = 3'd2;
	localparam logic [2:0] KIND_NL        = 3'd3;
	localparam logic [2:0] KIND_READ      = 3'd4;
	localparam logic [2:0] KIND_NOT_READY = 3'd5;

	localparam logic [7:0] PLAIN_MAP [NUM_KEYS] = '{
		8'h00, 8'h1B, "1",   "2",   "3",   "4",   "5",   "6",   "7",   "8",
		"9",   "0",   8'h27, 8'hBF, 8'h00, 8'h09, "q",   "w",   "e",   "r",
		"t",   "y",   "u",   "i",   "o",   "p",   8'hB4, "+",   8'h0A, 8'h00,
		"a",   "s",   "d",   "f",   "g",   "h",   "j",   "k",   "l",   8'h00,
		"{",   "|",   8'h00, "}",   "z",   "x",   "c",   "v",   "b",   "n",
		"m",   ",",   ".",   "-",   8'h00, "*",   8'h00, " ",   8'h00, 8'h00
	};

	localparam logic [7:0] CAPS_MAP [NUM_KEYS] = '{
		8'h00, 8'h1B, "!",   8'h00, "#",   "$",   "%",   "&",   "/",   "(",
		")",   "=",   "?",   8'hA1, 8'h00, 8'h09, "Q",   "W",   "E",   "R",
		"T",   "Y",   "U",   "I",   "O",   "P",   8'hA8, "*",   8'h0A, 8'h00,
		"A",   "S",   "D",   "F",   "G",   "H",   "J",   "K",   "L",   8'h00,
		"[",   8'hB0, 8'h00, "]",   "Z",   "X",   "C",   "V",   "B",   "N",
		"M",   ";",   ":",   "_",   8'h00, "*",   8'h00, " ",   8'h00, 8'h00
	};

	typedef struct packed {
		logic load_item;
		logic exec_single;
		logic sel_rd;
		logic rd_emit;
	} scb_cmd_t;

	typedef struct packed {
		logic is_read;
		logic read_ok;
		logic out_free;
		logic rd_stop;
	} scb_status_t;

endpackage

// File: design/scb_if.sv
// Interfaces: request and result channels of the scan code line buffer.
interface scb_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] scan_code;
	logic [4:0] read_count;

	modport source (output valid, output action, output scan_code, output read_count,
		input ready);
	modport sink (input valid, input action, input scan_code, input read_count,
		output ready);
endinterface

interface scb_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, output kind, output char_out, output last, input ready);
	modport sink (input valid, input kind, input char_out, input last, output ready);
endinterface

// File: design/scb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: design/scb_ctrl.sv
// Controller: sequences transaction intake, key execution and the read loop.
module scb_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  scb_pkg::scb_status_t status,
	output scb_pkg::scb_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_EXEC    = 2'd1;
	localparam logic [1:0] ST_RD_ADDR = 2'd2;
	localparam logic [1:0] ST_RD_DATA = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d         = state_q;
		cmd.load_item   = 1'b0;
		cmd.exec_single = 1'b0;
		cmd.sel_rd      = 1'b0;
		cmd.rd_emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.is_read && status.read_ok) begin
					state_d = ST_RD_ADDR;
				end else if (status.out_free) begin
					cmd.exec_single = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_RD_ADDR: begin
				cmd.sel_rd = 1'b1;
				state_d    = ST_RD_DATA;
			end
			ST_RD_DATA: begin
				cmd.sel_rd = 1'b1;
				if (status.out_free) begin
					cmd.rd_emit = 1'b1;
					state_d     = status.rd_stop ? ST_IDLE : ST_RD_ADDR;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/scb_dp.sv
// Datapath: item registers, key decode, ring buffer pointers and result register.
module scb_dp #(
	parameter int BUFFER_DEPTH = scb_pkg::BUFFER_DEPTH,
	parameter int MAX_READ     = scb_pkg::MAX_READ
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  scb_pkg::scb_cmd_t    cmd,
	output scb_pkg::scb_status_t status,
	input  logic                 req_action,
	input  logic [7:0]           req_scan_code,
	input  logic [4:0]           req_read_count,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output logic [2:0]           rsp_kind,
	output logic [7:0]           rsp_char_out,
	output logic                 rsp_last
);

	localparam int PTR_W  = $clog2(BUFFER_DEPTH);
	localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
	localparam int WANT_W = $clog2(MAX_READ + 1);

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(BUFFER_DEPTH - 1) : p - PTR_W'(1);
	endfunction

	logic              action_q;
	logic [7:0]        code_q;
	logic [WANT_W-1:0] want_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [FILL_W-1:0] fill_q;
	logic              caps_q;
	logic              line_q;
	logic              out_valid_q;
	logic [2:0]        kind_q;
	logic [7:0]        char_q;
	logic              last_q;

	logic              ram_we;
	logic [PTR_W-1:0]  ram_raddr;
	logic [7:0]        ram_rdata;

	logic [WANT_W-1:0] want_d;
	logic [5:0]        key_idx;
	logic              is_digit;
	logic [7:0]        key_char;
	logic [2:0]        k_kind;
	logic [7:0]        k_char;
	logic              k_push;
	logic              k_bs;
	logic              k_caps;
	logic              k_line;
	logic              key_exec;
	logic              rd_nl;

	assign want_d = (32'(req_read_count) > MAX_READ) ? WANT_W'(MAX_READ)
		: WANT_W'(req_read_count);

	assign key_idx  = (code_q < 8'(scb_pkg::NUM_KEYS)) ? code_q[5:0] : 6'd0;
	assign is_digit = (code_q >= scb_pkg::DIGIT_LO) && (code_q <= scb_pkg::DIGIT_HI);
	assign key_char = (caps_q && !is_digit) ? scb_pkg::CAPS_MAP[key_idx]
		: scb_pkg::PLAIN_MAP[key_idx];

	always_comb begin
		k_kind = scb_pkg::KIND_NONE;
		k_char = 8'h00;
		k_push = 1'b0;
		k_bs   = 1'b0;
		k_caps = 1'b0;
		k_line = 1'b0;
		if (code_q >= 8'(scb_pkg::NUM_KEYS)) begin
			k_kind = scb_pkg::KIND_NONE;
		end else if (code_q == scb_pkg::CODE_BACKSPACE) begin
			// prev entry read back from RAM; a newline is never erased
			if (fill_q != '0 && ram_rdata != scb_pkg::CH_NEWLINE) begin
				k_kind = scb_pkg::KIND_BS;
				k_char = scb_pkg::CH_BACKSPACE;
				k_bs   = 1'b1;
			end
		end else if (code_q == scb_pkg::CODE_ENTER) begin
			if (fill_q != FILL_W'(BUFFER_DEPTH)) begin
				k_kind = scb_pkg::KIND_NL;
				k_char = scb_pkg::CH_NEWLINE;
				k_push = 1'b1;
				k_line = 1'b1;
			end
		end else if (code_q == scb_pkg::CODE_CAPS) begin
			k_caps = 1'b1;
		end else if (key_char != 8'h00 && fill_q < FILL_W'(BUFFER_DEPTH - 1)) begin
			// last slot is kept for a newline
			k_kind = scb_pkg::KIND_ECHO;
			k_char = key_char;
			k_push = 1'b1;
		end
	end

	assign key_exec  = cmd.exec_single && !action_q;
	assign ram_we    = key_exec && k_push;
	assign ram_raddr = cmd.sel_rd ? rp_q : ptr_prev(wp_q);
	assign rd_nl     = (ram_rdata == scb_pkg::CH_NEWLINE);

	scb_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q),
		.wdata (k_char),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign status.is_read  = action_q;
	assign status.read_ok  = (want_q != '0) && (32'(fill_q) >= 32'(want_q)) && line_q;
	assign status.out_free = !out_valid_q || rsp_ready;
	assign status.rd_stop  = rd_nl || (want_q == WANT_W'(1));

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= req_action;
			code_q   <= req_scan_code;
			want_q   <= want_d;
		end else if (cmd.rd_emit) begin
			want_q <= want_q - WANT_W'(1);
		end
		if (cmd.exec_single) begin
			kind_q <= action_q ? scb_pkg::KIND_NOT_READY : k_kind;
			char_q <= action_q ? 8'h00 : k_char;
			last_q <= 1'b1;
		end else if (cmd.rd_emit) begin
			kind_q <= scb_pkg::KIND_READ;
			char_q <= ram_rdata;
			last_q <= status.rd_stop;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			fill_q      <= '0;
			caps_q      <= 1'b0;
			line_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (key_exec) begin
				if (k_push) begin
					wp_q   <= ptr_next(wp_q);
					fill_q <= fill_q + FILL_W'(1);
				end else if (k_bs) begin
					wp_q   <= ptr_prev(wp_q);
					fill_q <= fill_q - FILL_W'(1);
				end
				if (k_caps) begin
					caps_q <= !caps_q;
				end
				if (k_line) begin
					line_q <= 1'b1;
				end
			end else if (cmd.rd_emit) begin
				rp_q   <= ptr_next(rp_q);
				fill_q <= fill_q - FILL_W'(1);
				if (rd_nl) begin
					line_q <= 1'b0;
				end
			end
			if (cmd.exec_single || cmd.rd_emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid    = out_valid_q;
	assign rsp_kind     = kind_q;
	assign rsp_char_out = char_q;
	assign rsp_last     = last_q;

endmodule

// File: design/scan_code_line_buffer_unit.sv
// Top level: keyboard line buffer fed by set-1 scan codes, with read requests.
//
// Channels: req carries one transaction per key event (action 0, scan_code) or
// read request (action 1, read_count). rsp carries result transactions with kind,
// char_out and last; last marks the final result of a request.
// Sequencing: req is taken only while the controller is idle. A key event or a
// refused read gives its single result from the execute state once the output
// register is free, and the next request is taken after that result is loaded. A
// read takes an address state and a data state per character for the registered
// read of the character RAM; no request is taken until its last result is loaded.
// Reset: pointers, fill count, caps lock and line-ready flags clear at once; the
// character RAM is not cleared and is only read at written entries.
// Stall: a result waits in the output register while rsp.ready is low; the
// controller holds its state until the register frees, so nothing is lost.
module scan_code_line_buffer_unit #(
	parameter int BUFFER_DEPTH = scb_pkg::BUFFER_DEPTH,
	parameter int MAX_READ     = scb_pkg::MAX_READ
) (
	input logic       clk,
	input logic       arst_n,
	scb_req_if.sink   req,
	scb_rsp_if.source rsp
);

	scb_pkg::scb_cmd_t    cmd;
	scb_pkg::scb_status_t status;

	scb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	scb_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.MAX_READ     (MAX_READ)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.req_action     (req.action),
		.req_scan_code  (req.scan_code),
		.req_read_count (req.read_count),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_kind       (rsp.kind),
		.rsp_char_out   (rsp.char_out),
		.rsp_last       (rsp.last)
	);

endmodule

// File: design/scb_checker.sv
// Checker: port-level assertions for the scan code line buffer, bound to the top.
`include "scan_code_line_buffer_unit_defines.svh"

module scb_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [2:0] rsp_kind,
	input logic [7:0] rsp_char_out,
	input logic       rsp_last
);

	`SCB_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_char_out) && $stable(rsp_last), "result changed while stalled")

	`SCB_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")

	`SCB_ASSERT_IMP(a_single_last, rsp_valid && rsp_kind != scb_pkg::KIND_READ, rsp_last, "single result without last")

	`SCB_ASSERT_IMP(a_kind_range, rsp_valid, rsp_kind <= scb_pkg::KIND_NOT_READY, "result kind out of range")

	`SCB_ASSERT_IMP(a_empty_char, rsp_valid && (rsp_kind == scb_pkg::KIND_NONE || rsp_kind == scb_pkg::KIND_NOT_READY), rsp_char_out == 8'h00, "nonzero char on empty result")

endmodule

bind scan_code_line_buffer_unit scb_checker u_scb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_kind     (rsp.kind),
	.rsp_char_out (rsp.char_out),
	.rsp_last     (rsp.last)
);
